// ----- src/ppc_exu_pkg.sv -----
// ---------------------------------------------------------------------------
// ppc_exu_pkg - shared types and constants of the PowerPC64 subset execute unit
// Action codes, compare flags, opcodes, extended opcodes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package ppc_exu_pkg;
	localparam logic [2:0] ACT_FETCH  = 3'd0;
	localparam logic [2:0] ACT_WBYTE  = 3'd1;
	localparam logic [2:0] ACT_WDWORD = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_PRINT  = 3'd4;
	localparam logic [2:0] ACT_HALT   = 3'd5;

	localparam logic [31:0] FLAG_LT = 32'h8000_0000;
	localparam logic [31:0] FLAG_GT = 32'h4000_0000;
	localparam logic [31:0] FLAG_EQ = 32'h2000_0000;

	localparam logic [5:0] OP_CMPI  = 6'd11;
	localparam logic [5:0] OP_ADDI  = 6'd14;
	localparam logic [5:0] OP_ADDIS = 6'd15;
	localparam logic [5:0] OP_BC    = 6'd16;
	localparam logic [5:0] OP_SC    = 6'd17;
	localparam logic [5:0] OP_B     = 6'd18;
	localparam logic [5:0] OP_BLR   = 6'd19;
	localparam logic [5:0] OP_ORI   = 6'd24;
	localparam logic [5:0] OP_ORIS  = 6'd25;
	localparam logic [5:0] OP_SHL   = 6'd30;
	localparam logic [5:0] OP_X     = 6'd31;
	localparam logic [5:0] OP_STB   = 6'd38;
	localparam logic [5:0] OP_LD    = 6'd58;
	localparam logic [5:0] OP_STD   = 6'd62;

	localparam logic [8:0] XO_ADD   = 9'd266;
	localparam logic [8:0] XO_SUBF  = 9'd40;
	localparam logic [8:0] XO_MULLD = 9'd233;
	localparam logic [8:0] XO_DIVDU = 9'd457;
	localparam logic [8:0] XO_MR    = 9'd444;
	localparam logic [8:0] XO_MFLR  = 9'd339;
	localparam logic [8:0] XO_MTLR  = 9'd467;
	localparam logic [8:0] XO_CMP   = 9'd0;
	localparam logic [8:0] XO_STBX  = 9'd215;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDA,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_OUT0,
		ST_OUT1
	} state_t;
endpackage
`default_nettype wire

// ----- src/ppc64_subset_execute_unit.sv -----
// ---------------------------------------------------------------------------
// ppc64_subset_execute_unit - PowerPC64 subset instruction executor
// Executes one fetched instruction per request and emits memory actions.
// ---------------------------------------------------------------------------
// Usage: send a request with opcode 0 and the instruction word fetched at the
// current pc, or opcode 1 with load data for a pending ld. The unit answers
// with zero, one or two result requests; the one with last=1 carries the next
// fetch address (or read, or halt). in_ready is low while a request is at work
// and until its results have been taken.
// Register operands come from a register file memory with one registered
// read port, one operand per cycle; stbx reads three operands, the other
// instructions two. mulld runs a shared shift-add unit and divdu a restoring
// divider, one bit per cycle. A new request is taken only once the last one
// is through and its results are taken; an instruction that arrives behind a
// pending ld is dropped, and stray load data gives no result.
// Reset clears the general registers through valid bits, sets pc to 0,
// clears link, compare field and load and halt status.
// A stalled receiver holds the result register; nothing advances until
// out_ready takes it. A cfg_we write loads pc from cfg_wdata; write only when idle.
// ---------------------------------------------------------------------------
`default_nettype none
module ppc64_subset_execute_unit #(
	parameter int REGISTER_COUNT = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [31:0] instr_word,
	input  wire logic [63:0] load_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [63:0]      address,
	output logic [63:0]      write_data,
	output logic             last
);
	import ppc_exu_pkg::*;
	localparam int RW = $clog2(REGISTER_COUNT);

	state_t state_q, state_nx;
	logic [63:0] rf_mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] rf_vld_q;
	logic [63:0] rd_data_q;
	logic        rd_vld_q;
	logic [RW-1:0] rd_addr;
	logic [63:0] a_q, b_q;  // a: ra/rt-source operand, b: second
	logic [63:0] c_q;       // third operand, base register of stbx
	logic [63:0] pc_q, lr_q;
	logic [31:0] cr_q;
	logic        ldp_q, halt_q;
	logic [RW-1:0] ldt_q;
	logic [31:0] w_q;
	logic        op_q;
	logic [63:0] ld_q;
	logic [1:0]  rdsel_q; // which operand read is under way
	// iterative unit
	logic [63:0] acc_q, mq_q, md_q;
	logic [6:0]  cnt_q;
	// results
	logic [2:0]  act0_q, act1_q;
	logic [63:0] adr0_q, adr1_q, dat0_q;
	logic        two_q;
	logic        wen;
	logic [RW-1:0] wadr;
	logic [63:0] wval;

	logic [5:0] op;
	logic [4:0] rt, ra, rb;
	logic [8:0] xo;
	logic [63:0] si, ds, sih, bd;
	assign op = w_q[31:26];
	assign rt = w_q[25:21];
	assign ra = w_q[20:16];
	assign rb = w_q[15:11];
	assign xo = w_q[9:1];
	assign si = {{48{w_q[15]}}, w_q[15:0]};
	assign ds = {{48{w_q[15]}}, w_q[15:2], 2'b00};
	assign sih = {{32{w_q[15]}}, w_q[15:0], 16'h0000};
	assign bd = {{38{w_q[25]}}, w_q[25:2], 2'b00};

	// First operand register: rt for stores/ori/mr/mtlr, else ra.
	logic first_rt;
	always_comb begin
		first_rt = 1'b0;
		case (op)
			OP_ORI, OP_ORIS, OP_STB: first_rt = 1'b1;
			OP_STD: first_rt = 1'b1;
			OP_X: first_rt = (xo == XO_MR) || (xo == XO_MTLR) || (xo == XO_STBX);
			default: first_rt = 1'b0;
		endcase
	end

	// stbx needs rt, rb and ra: read ra in a third slot.
	logic three_rd;
	assign three_rd = (op == OP_X) && (xo == XO_STBX);

	always_comb begin
		rd_addr = RW'(ra);
		if (rdsel_q == 2'd0) begin
			if (op == OP_SC) rd_addr = RW'(5'd4);
			else if (first_rt) rd_addr = RW'(rt);
		end else if (rdsel_q == 2'd1) begin
			if (op == OP_SC) rd_addr = RW'(5'd0);
			else if (op == OP_STB || op == OP_STD || op == OP_LD) rd_addr = RW'(ra);
			else rd_addr = RW'(rb);
		end
	end

	// Register file memory, one read and one write port.
	always_ff @(posedge clk) begin
		if (wen) rf_mem[wadr] <= wval;
		rd_data_q <= rf_mem[rd_addr];
	end

	logic [63:0] rdv;
	assign rdv = rd_vld_q ? rd_data_q : 64'h0;
	// base register: ra==0 reads zero except stdu
	logic [63:0] base;
	assign base = (ra == 5'd0 && !(op == OP_STD && w_q[1:0] == 2'd1)) ? 64'h0 : b_q;
	logic [63:0] a_base;
	assign a_base = (ra == 5'd0) ? 64'h0 : a_q;

	// Divider step
	logic [64:0] rem_sh, rem_sub;
	assign rem_sh = {acc_q, mq_q[63]};
	assign rem_sub = rem_sh - {1'b0, md_q};

	logic [2:0] flags, pat;
	logic take;
	logic sa_lt, s_eq;
	logic [63:0] cmp_b;
	assign cmp_b = (op == OP_CMPI) ? si : b_q;
	assign sa_lt = $signed(a_q) < $signed(cmp_b);
	assign s_eq = a_q == cmp_b;
	assign flags = cr_q[31:29];
	always_comb begin
		case (ra)
			5'd0: pat = 3'd4;
			5'd1: pat = 3'd2;
			5'd2: pat = 3'd1;
			default: pat = 3'd0;
		endcase
	end
	assign take = (pat != 3'd0) && ((w_q[25:23] == 3'd1 && flags != pat) ||
		(w_q[25:23] == 3'd3 && flags == pat));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				if (halt_q || opcode) state_nx = ST_EXEC;
				else if (!ldp_q) state_nx = ST_RDA;
			end
			ST_RDA: if (rdsel_q == (three_rd ? 2'd3 : 2'd2)) state_nx = ST_EXEC;
			ST_EXEC: begin
				state_nx = ST_OUT0;
				if (!halt_q && !op_q && op == OP_X && xo == XO_MULLD) state_nx = ST_MUL;
				if (!halt_q && !op_q && op == OP_X && xo == XO_DIVDU && b_q != 64'h0)
					state_nx = ST_DIV;
				if (!halt_q && op_q && !ldp_q) state_nx = ST_IDLE;
			end
			ST_MUL, ST_DIV: if (cnt_q == 7'd63) state_nx = ST_OUT0;
			ST_OUT0: if (out_ready) state_nx = two_q ? ST_OUT1 : ST_IDLE;
			ST_OUT1: if (out_ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		action = (state_q == ST_OUT1) ? act1_q : act0_q;
		address = (state_q == ST_OUT1) ? adr1_q : adr0_q;
		write_data = (state_q == ST_OUT1) ? 64'h0 : dat0_q;
		last = (state_q == ST_OUT1) || !two_q;
	end

	// Write back selection in the execute stage and at the end of mulld/divdu.
	always_comb begin
		wen = 1'b0;
		wadr = RW'(rt);
		wval = 64'h0;
		if (state_q == ST_EXEC && !halt_q) begin
			if (op_q) begin
				wen = ldp_q;
				wadr = ldt_q;
				wval = ld_q;
			end else begin
				case (op)
					OP_ADDI: begin wen = 1'b1; wval = a_base + si; end
					OP_ADDIS: begin wen = 1'b1; wval = a_base + sih; end
					OP_ORI: begin wen = 1'b1; wadr = RW'(ra); wval = a_q | {48'h0, w_q[15:0]}; end
					OP_ORIS: begin
						wen = 1'b1; wadr = RW'(ra);
						wval = a_q | {32'h0, w_q[15:0], 16'h0};
					end
					OP_SHL: begin wen = 1'b1; wadr = RW'(ra); wval = {a_q[31:0], 32'h0}; end
					OP_STD: if (w_q[1:0] == 2'd1) begin
						wen = 1'b1; wadr = RW'(ra); wval = b_q + ds;
					end
					OP_X: begin
						case (xo)
							XO_ADD: begin wen = 1'b1; wval = a_q + b_q; end
							XO_SUBF: begin wen = 1'b1; wval = b_q - a_q; end
							XO_DIVDU: if (b_q == 64'h0) begin wen = 1'b1; wval = 64'h0; end
							XO_MR: begin wen = 1'b1; wadr = RW'(ra); wval = a_q; end
							XO_MFLR: begin wen = 1'b1; wval = lr_q; end
							default: wen = 1'b0;
						endcase
					end
					default: wen = 1'b0;
				endcase
			end
		end else if ((state_q == ST_MUL || state_q == ST_DIV) && cnt_q == 7'd63) begin
			wen = 1'b1;
			wval = (state_q == ST_MUL) ? (acc_q + (mq_q[0] ? md_q : 64'h0))
				: {mq_q[62:0], !rem_sub[64]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rf_vld_q <= '0;
			pc_q <= 64'h0;
			lr_q <= 64'h0;
			cr_q <= 32'h0;
			ldp_q <= 1'b0;
			ldt_q <= '0;
			halt_q <= 1'b0;
			rdsel_q <= 2'd0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_vld_q <= rf_vld_q[rd_addr];
			if (wen) rf_vld_q[wadr] <= 1'b1;
			if (cfg_we) pc_q <= cfg_wdata;
			if (state_q == ST_IDLE) rdsel_q <= 2'd0;
			if (state_q == ST_RDA) rdsel_q <= rdsel_q + 2'd1;
			if (state_q == ST_EXEC && !halt_q) begin
				if (op_q) begin
					if (ldp_q) begin ldp_q <= 1'b0; pc_q <= pc_q + 64'd4; end
				end else begin
					case (op)
						OP_CMPI: cr_q <= sa_lt ? FLAG_LT : (s_eq ? FLAG_EQ : FLAG_GT);
						OP_BC: pc_q <= take ? pc_q + ds : pc_q + 64'd4;
						OP_SC: if (b_q == 64'd1) halt_q <= 1'b1;
							else pc_q <= pc_q + 64'd4;
						OP_B: begin
							if (w_q[0]) lr_q <= pc_q + 64'd4;
							pc_q <= pc_q + bd;
						end
						OP_BLR: pc_q <= lr_q;
						OP_LD: begin ldp_q <= 1'b1; ldt_q <= RW'(rt); end
						OP_ADDI, OP_ADDIS, OP_ORI, OP_ORIS, OP_SHL, OP_STB:
							pc_q <= pc_q + 64'd4;
						OP_STD: if (w_q[1]) halt_q <= 1'b1; else pc_q <= pc_q + 64'd4;
						OP_X: begin
							case (xo)
								XO_CMP: begin
									cr_q <= sa_lt ? FLAG_LT : (s_eq ? FLAG_EQ : FLAG_GT);
									pc_q <= pc_q + 64'd4;
								end
								XO_MTLR: begin lr_q <= a_q; pc_q <= pc_q + 64'd4; end
								XO_ADD, XO_SUBF, XO_MULLD, XO_DIVDU, XO_MR, XO_MFLR, XO_STBX:
									pc_q <= pc_q + 64'd4;
								default: halt_q <= 1'b1;
							endcase
						end
						default: halt_q <= 1'b1;
					endcase
					if (op == OP_CMPI) pc_q <= pc_q + 64'd4;
				end
			end
		end
	end

	// Payload registers.
	logic [63:0] pc4;
	assign pc4 = pc_q + 64'd4;
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			w_q <= instr_word;
			op_q <= opcode;
			ld_q <= load_data;
		end
		if (state_q == ST_RDA) begin
			if (rdsel_q == 2'd1) a_q <= rdv;
			if (rdsel_q == 2'd2) b_q <= rdv;
			if (rdsel_q == 2'd3) c_q <= rdv;
		end
		if (state_q == ST_EXEC) begin
			acc_q <= 64'h0;
			mq_q <= (op == OP_X && xo == XO_MULLD) ? b_q : a_q;
			md_q <= (op == OP_X && xo == XO_MULLD) ? a_q : b_q;
			cnt_q <= 7'd0;
			two_q <= 1'b0;
			dat0_q <= 64'h0;
			act0_q <= ACT_FETCH;
			adr0_q <= pc4;
			act1_q <= ACT_FETCH;
			adr1_q <= pc4;
			if (halt_q) begin
				act0_q <= ACT_HALT;
				adr0_q <= pc_q;
			end else if (!op_q) begin
				case (op)
					OP_BC: adr0_q <= take ? pc_q + ds : pc4;
					OP_SC: if (b_q == 64'd1) begin
						act0_q <= ACT_HALT; adr0_q <= pc_q;
					end else begin
						two_q <= 1'b1; act0_q <= ACT_PRINT; adr0_q <= a_q;
					end
					OP_B: adr0_q <= pc_q + bd;
					OP_BLR: adr0_q <= lr_q;
					OP_LD: begin act0_q <= ACT_READ; adr0_q <= base + ds; end
					OP_STB: begin
						two_q <= 1'b1; act0_q <= ACT_WBYTE; adr0_q <= base + si;
						dat0_q <= {56'h0, a_q[7:0]};
					end
					OP_STD: if (w_q[1]) begin
						act0_q <= ACT_HALT; adr0_q <= pc_q;
					end else begin
						two_q <= 1'b1; act0_q <= ACT_WDWORD; adr0_q <= base + ds;
						dat0_q <= a_q;
					end
					OP_CMPI, OP_ADDI, OP_ADDIS, OP_ORI, OP_ORIS, OP_SHL: act0_q <= ACT_FETCH;
					OP_X: begin
						case (xo)
							XO_STBX: begin
								two_q <= 1'b1; act0_q <= ACT_WBYTE;
								adr0_q <= ((ra == 5'd0) ? 64'h0 : c_q) + b_q;
								dat0_q <= {56'h0, a_q[7:0]};
							end
							XO_ADD, XO_SUBF, XO_MULLD, XO_DIVDU, XO_MR, XO_MFLR, XO_MTLR,
							XO_CMP: act0_q <= ACT_FETCH;
							default: begin act0_q <= ACT_HALT; adr0_q <= pc_q; end
						endcase
					end
					default: begin act0_q <= ACT_HALT; adr0_q <= pc_q; end
				endcase
			end
		end
		if (state_q == ST_MUL) begin
			acc_q <= acc_q + (mq_q[0] ? md_q : 64'h0);
			mq_q <= {1'b0, mq_q[63:1]};
			md_q <= {md_q[62:0], 1'b0};
			cnt_q <= cnt_q + 7'd1;
		end
		if (state_q == ST_DIV) begin
			acc_q <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
			mq_q <= {mq_q[62:0], !rem_sub[64]};
			cnt_q <= cnt_q + 7'd1;
		end
	end
endmodule
`default_nettype wire
